// File: hdl/llpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llpa_pkg: shared types and constants of the least-loaded pool allocator
// Holds the transfer payload structs, the opcode and cell command codes, and
// the fixed field widths used by the cells and the top level.
// ----------------------------------------------------------------------------
package llpa_pkg;

    localparam int CNT_W       = 16;
    localparam int OPEN_W      = 5;
    localparam int SLOT_W      = 4;
    localparam int MAX_CH_DEF  = 16;

    localparam logic [OPEN_W-1:0] MAX_CH_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_DONE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    // Command broadcast to the selected cell when an item commits.
    typedef enum logic [2:0] {
        COP_NOP  = 3'd0,
        COP_INC  = 3'd1,
        COP_SET1 = 3'd2,
        COP_DEC  = 3'd3,
        COP_CLR  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_opcode           opcode;
        logic [SLOT_W-1:0] slot_index;
        logic              slot_failed;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] grant_index;
        logic              opened_new;
        logic              slot_replaced;
        logic [OPEN_W-1:0] open_slots;
        logic [CNT_W-1:0]  handles_out;
    } t_out_item;

    // Running minimum handed from cell to cell during a scan.
    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] cnt;
    } t_best;

endpackage

// File: hdl/llpa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llpa_cell: one slot of the pool
// Holds the in-use count of one slot. During a scan it folds its count into
// the running minimum passed from its left neighbor and registers the result
// for the next cell. On a commit it applies the broadcast command if selected.
// ----------------------------------------------------------------------------
module llpa_cell
    import llpa_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok,
    input  t_best             i_best,
    input  logic [IW-1:0]     i_best_idx,
    input  logic [OPEN_W-1:0] i_open,
    input  logic              i_sel,
    input  t_cell_op          i_op,
    output logic              o_tok,
    output t_best             o_best,
    output logic [IW-1:0]     o_best_idx
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_tok;
    t_best            r_best;
    logic [IW-1:0]    r_best_idx;
    logic             w_active;
    logic             w_take;

    assign w_active = (32'(IDX) < 32'(i_open));
    assign w_take   = w_active && (!i_best.found || (r_cnt < i_best.cnt));

    always_comb begin
        n_cnt = r_cnt;
        if (i_sel) begin
            case (i_op)
                COP_INC:  n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
                COP_SET1: n_cnt = CNT_W'(1);
                COP_DEC:  n_cnt = (r_cnt == '0) ? r_cnt : r_cnt - 1'b1;
                COP_CLR:  n_cnt = '0;
                default:  n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tok <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            if (w_take) begin
                r_best.found <= 1'b1;
                r_best.cnt   <= r_cnt;
                r_best_idx   <= IW'(IDX);
            end else begin
                r_best     <= i_best;
                r_best_idx <= i_best_idx;
            end
        end
    end

    assign o_tok      = r_tok;
    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

// File: hdl/least_loaded_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_pool_allocator: least-loaded slot allocator over a cell chain
// Keeps per-slot in-use counts in a row of cells, the number of open slots
// and the outstanding handle total, and answers acquire, done and release
// operations with one result each.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_stall    i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall  o_out_data (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (max_channels)
//
//  An acquire passes through the scan state between its transfer and its
//  commit, since the minimum search walks the cell chain one cell per cycle.
//  Done, release and no-op items go straight from transfer to the commit state.
//  The result sits in an output register, so a new item is taken while it
//  waits; a commit waits only when that register is full and stalled.
//  Synchronous active-low reset clears the state, counts and output valid, and sets max_channels to 16.
// ----------------------------------------------------------------------------
module least_loaded_pool_allocator
    import llpa_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [OPEN_W-1:0] i_cfg_data
);

    localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic              r_start;
    logic [OPEN_W-1:0] r_open, n_open;
    logic [CNT_W-1:0]  r_handles, n_handles;
    logic [OPEN_W-1:0] r_max_ch;
    logic              r_out_vld;
    t_out_item         r_out, n_out;

    logic                    w_in_xfer;
    logic                    w_fire;
    logic [OPEN_W-1:0]       w_limit;
    logic                    w_open_new;
    logic [31:0]             w_target;
    logic                    w_target_en;
    t_cell_op                w_op;
    logic [MAX_CHANNELS-1:0] w_sel;
    logic                    w_done_ok;

    logic                    w_tok   [MAX_CHANNELS+1];
    t_best                   w_best  [MAX_CHANNELS+1];
    logic [IW-1:0]           w_bidx  [MAX_CHANNELS+1];

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_fire      = (r_state == ST_COMMIT) && (!r_out_vld || !i_out_stall);

    // Head of the chain: an empty running minimum, started once per acquire.
    assign w_tok[0]  = r_start;
    assign w_best[0] = '0;
    assign w_bidx[0] = '0;

    genvar g;
    generate
        for (g = 0; g < MAX_CHANNELS; g++) begin : g_cell
            llpa_cell #(
                .IDX (g),
                .IW  (IW)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_tok      (w_tok[g]),
                .i_best     (w_best[g]),
                .i_best_idx (w_bidx[g]),
                .i_open     (r_open),
                .i_sel      (w_sel[g]),
                .i_op       (w_op),
                .o_tok      (w_tok[g+1]),
                .o_best     (w_best[g+1]),
                .o_best_idx (w_bidx[g+1])
            );
            assign w_sel[g] = w_fire && w_target_en && (w_target == 32'(g));
        end
    endgenerate

    assign w_limit = (32'(r_max_ch) > 32'(MAX_CHANNELS)) ? OPEN_W'(MAX_CHANNELS) : r_max_ch;

    // A new slot opens when nothing is open, or when the least count is
    // nonzero and the limit still leaves room.
    assign w_open_new = !w_best[MAX_CHANNELS].found ||
                        ((w_best[MAX_CHANNELS].cnt != '0) && (r_open < w_limit));

    assign w_done_ok = (32'(r_item.slot_index) < 32'(r_open)) &&
                       (32'(r_item.slot_index) < 32'(MAX_CHANNELS));

    always_comb begin
        w_target    = 32'(r_item.slot_index);
        w_target_en = 1'b0;
        w_op        = COP_NOP;
        n_open      = r_open;
        n_handles   = r_handles;
        n_out       = '0;
        unique case (r_item.opcode)
            OP_ACQUIRE: begin
                w_target_en = 1'b1;
                if (w_open_new) begin
                    w_target = 32'(r_open);
                    w_op     = COP_SET1;
                    n_open   = r_open + 1'b1;
                end else begin
                    w_target = 32'(w_bidx[MAX_CHANNELS]);
                    w_op     = COP_INC;
                end
                n_handles         = (r_handles == '1) ? r_handles : r_handles + 1'b1;
                n_out.grant_index = w_target[SLOT_W-1:0];
                n_out.opened_new  = w_open_new;
            end
            OP_DONE: begin
                w_target_en         = w_done_ok;
                w_op                = r_item.slot_failed ? COP_CLR : COP_DEC;
                n_out.slot_replaced = w_done_ok && r_item.slot_failed;
            end
            OP_RELEASE: begin
                n_handles = (r_handles == '0) ? r_handles : r_handles - 1'b1;
            end
            OP_NONE: begin
                w_op = COP_NOP;
            end
            default: begin
                w_op = COP_NOP;
            end
        endcase
        n_out.open_slots  = n_open;
        n_out.handles_out = n_handles;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = (i_in_data.opcode == OP_ACQUIRE) ? ST_SCAN : ST_COMMIT;
                end
            end
            ST_SCAN: begin
                if (w_tok[MAX_CHANNELS]) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start   <= 1'b0;
            r_open    <= '0;
            r_handles <= '0;
            r_max_ch  <= MAX_CH_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_in_xfer && (i_in_data.opcode == OP_ACQUIRE);
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_ch <= i_cfg_data;
            end
            if (w_fire) begin
                r_open    <= n_open;
                r_handles <= n_handles;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Opening a slot must never run past the end of the cell chain.
    a_open_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_item.opcode == OP_ACQUIRE) && w_open_new)
            |-> (32'(r_open) < 32'(MAX_CHANNELS)))
        else $error("acquire opened a slot beyond the cell chain");

    a_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one cell selected for a commit");

    // A fresh result appears only after a commit.
    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> $past(r_state == ST_COMMIT))
        else $error("result appeared without a commit");

    // The scan result arrives only while an acquire is scanning.
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[MAX_CHANNELS] |-> (r_state == ST_SCAN))
        else $error("scan finished outside of an acquire");

endmodule
